// ===== src/lcsre_pkg.sv =====
// Shared constants and command codes for the LCS length row engine.
`default_nettype none
package lcsre_pkg;

   localparam int MAX_LEN_DEFAULT = 128;
   localparam int SYM_W           = 8;
   localparam int OUT_W           = 8;
   localparam int CMD_W           = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_PROCESS = 2'd2
   } cmd_type;

endpackage
`default_nettype wire

// ===== src/lcsre_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module lcsre_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/lcsre_cell_unit.sv =====
// Shared DP cell update: diagonal plus one on a match, else max of top and left.
`default_nettype none
module lcsre_cell_unit import lcsre_pkg::*; #(
   parameter int LEN_W = 8
) (
   input  wire logic [SYM_W-1:0] stored_sym,
   input  wire logic [SYM_W-1:0] key_sym,
   input  wire logic [LEN_W-1:0] diag,
   input  wire logic [LEN_W-1:0] top,
   input  wire logic [LEN_W-1:0] left,
   output logic      [LEN_W-1:0] next_val
);

   always_comb begin
      if (stored_sym == key_sym) begin
         next_val = diag + LEN_W'(1);
      end else if (top >= left) begin
         next_val = top;
      end else begin
         next_val = left;
      end
   end

endmodule
`default_nettype wire

// ===== src/lcs_length_row_engine_top.sv =====
// Top level of the LCS length row engine: request handling, row sequencer, response register.
// Clear, append and unused-command requests are accepted whenever the sequencer is idle and
// the response register is free; an unused command gives no response. A process request
// sweeps the DP row one cell per cycle through the shared cell unit, reading the stored
// string and the row memory at the same address, in order: the accept, one cell per stored
// symbol, then the response load. With an empty first string it answers in the cycle after
// the accept. The row is zeroed by a single flag rather than a clearing pass, so no such pass
// runs after reset or on append. Lengths above 255 saturate.
`default_nettype none
module lcs_length_row_engine_top import lcsre_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [CMD_W-1:0] req_cmd,
   input  wire logic [SYM_W-1:0] req_symbol,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [OUT_W-1:0] rsp_lcs_length,
   output logic                  rsp_first_overflow
);

   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W = $clog2(MAX_LEN + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             row_zero_ff, row_zero_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0] diag_ff, diag_in;
   logic [LEN_W-1:0] res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_len_ff, rsp_len_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             accept;
   logic             rsp_free;
   logic             not_full;
   logic             last_cell;
   logic [IDX_W-1:0] rd_addr;
   logic             store_we;
   logic             row_we;
   logic [SYM_W-1:0] store_q;
   logic [LEN_W-1:0] row_q;
   logic [LEN_W-1:0] top_val;
   logic [LEN_W-1:0] cell_val;

   function automatic logic [OUT_W-1:0] sat_len(input logic [LEN_W-1:0] v);
      if (32'(v) > 32'd255) begin
         return {OUT_W{1'b1}};
      end
      return OUT_W'(v);
   endfunction

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;
   assign not_full  = len_ff < LEN_W'(MAX_LEN);
   assign last_cell = idx_ff == IDX_W'(len_ff - LEN_W'(1));
   assign rd_addr   = (state_ff == ST_SWEEP) ? idx_ff + IDX_W'(1) : '0;
   assign store_we  = accept && (req_cmd == CMD_APPEND) && not_full;
   assign row_we    = state_ff == ST_SWEEP;
   assign top_val   = row_zero_ff ? '0 : row_q;

   lcsre_ram #(
      .WIDTH  (SYM_W),
      .DEPTH  (MAX_LEN),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (req_symbol),
      .rd_addr (rd_addr),
      .rd_data (store_q)
   );

   lcsre_ram #(
      .WIDTH  (LEN_W),
      .DEPTH  (MAX_LEN),
      .ADDR_W (IDX_W)
   ) u_row (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (idx_ff),
      .wr_data (cell_val),
      .rd_addr (rd_addr),
      .rd_data (row_q)
   );

   lcsre_cell_unit #(
      .LEN_W (LEN_W)
   ) u_cell (
      .stored_sym (store_q),
      .key_sym    (sym_ff),
      .diag       (diag_ff),
      .top        (top_val),
      .left       (left_ff),
      .next_val   (cell_val)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      row_zero_in  = row_zero_ff;
      sym_in       = sym_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_CLEAR: begin
                     len_in       = '0;
                     ovf_in       = 1'b0;
                     row_zero_in  = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_len_in   = '0;
                     rsp_ovf_in   = 1'b0;
                  end
                  CMD_APPEND: begin
                     if (not_full) begin
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     row_zero_in  = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_len_in   = '0;
                     rsp_ovf_in   = ovf_ff || !not_full;
                  end
                  CMD_PROCESS: begin
                     if (len_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_len_in   = '0;
                        rsp_ovf_in   = ovf_ff;
                     end else begin
                        sym_in   = req_symbol;
                        idx_in   = '0;
                        left_in  = '0;
                        diag_in  = '0;
                        state_in = ST_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            left_in = cell_val;
            diag_in = top_val;
            idx_in  = idx_ff + IDX_W'(1);
            if (last_cell) begin
               res_in      = cell_val;
               row_zero_in = 1'b0;
               state_in    = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = sat_len(res_ff);
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         row_zero_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         row_zero_ff  <= row_zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff     <= sym_in;
      idx_ff     <= idx_in;
      left_ff    <= left_in;
      diag_ff    <= diag_in;
      res_ff     <= res_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lcs_length     = rsp_len_ff;
   assign rsp_first_overflow = rsp_ovf_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_LEN))
      else $error("first string length beyond store depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LEN_W'(MAX_LEN)))
      else $error("overflow flagged while store not full");

   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_CLEAR))
         |=> (rsp_valid && (rsp_lcs_length == '0) && !rsp_first_overflow))
      else $error("clear request did not return a zero response");

   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_PROCESS) && (len_ff != '0)) |=> !req_ready)
      else $error("new request taken during row sweep");

endmodule
`default_nettype wire
